FILE: hdl/mdwc_pkg.sv
package mdwc_pkg;

    // default configuration of the top level
    localparam int WINDOW_MAX_DEF  = 16;
    localparam int COORD_WIDTH_DEF = 32;

    // width of the window length register and its value after reset
    localparam int          WINDOW_LEN_W   = 5;
    localparam logic [4:0]  WINDOW_LEN_RST = 5'd10;

    // three coordinate lanes: x, y, z
    localparam int LANES = 3;

    // digit width of the serial squarer
    localparam int DIGIT_W = 4;

    // handshake between the top level and the distance unit
    typedef struct packed {
        logic busy;
        logic done;
    } mdwc_dist_stat_t;

endpackage

FILE: hdl/mdwc_dist.sv
module mdwc_dist
    import mdwc_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    localparam int MAG_W  = COORD_WIDTH + 1,
    localparam int ROOT_W = MAG_W
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [LANES-1:0][MAG_W-1:0] mag,
    output mdwc_dist_stat_t             stat,
    output logic [ROOT_W-1:0]           root
);

    localparam int NDIG   = (MAG_W + DIGIT_W - 1) / DIGIT_W;
    localparam int PAD_W  = NDIG * DIGIT_W;
    localparam int RAD_W  = 2 * MAG_W;
    localparam int REM_W  = ROOT_W + 2;
    localparam int CNT_W  = $clog2(ROOT_W);
    localparam int ADD_W  = MAG_W + DIGIT_W + 2;

    typedef enum logic [2:0] {
        DS_IDLE   = 3'b001,
        DS_SQUARE = 3'b010,
        DS_ROOT   = 3'b100
    } dist_state_t;

    dist_state_t              state_reg, state_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     done_reg, done_next;
    logic [LANES-1:0][MAG_W-1:0] mag_reg, mag_next;
    logic [LANES-1:0][PAD_W-1:0] dig_reg, dig_next;
    logic [RAD_W-1:0]         acc_reg, acc_next;
    logic [REM_W-1:0]         rem_reg, rem_next;
    logic [ROOT_W-1:0]        root_reg, root_next;

    logic [ADD_W-1:0]         prod_sum;
    logic [REM_W-1:0]         rem_sh;
    logic [REM_W-1:0]         trial;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        mag_next   = mag_reg;
        dig_next   = dig_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;

        // sum of the three partial products for the current digit
        prod_sum = '0;
        for (int l = 0; l < LANES; l++)
        begin
            prod_sum = prod_sum + ADD_W'(mag_reg[l]) * ADD_W'(dig_reg[l][PAD_W-1 -: DIGIT_W]);
        end

        // one root bit per cycle, radicand taken two bits at a time from acc
        rem_sh = {rem_reg[REM_W-3:0], acc_reg[RAD_W-1 -: 2]};
        trial  = {root_reg, 2'b01};

        unique case (state_reg)
            DS_IDLE:
            begin
                if (start)
                begin
                    mag_next = mag;
                    for (int l = 0; l < LANES; l++)
                    begin
                        dig_next[l] = PAD_W'(mag[l]);
                    end
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = DS_SQUARE;
                end
            end
            DS_SQUARE:
            begin
                acc_next = (acc_reg << DIGIT_W) + RAD_W'(prod_sum);
                for (int l = 0; l < LANES; l++)
                begin
                    dig_next[l] = dig_reg[l] << DIGIT_W;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NDIG - 1))
                begin
                    cnt_next   = '0;
                    rem_next   = '0;
                    root_next  = '0;
                    state_next = DS_ROOT;
                end
            end
            DS_ROOT:
            begin
                acc_next = acc_reg << 2;
                if (rem_sh >= trial)
                begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh;
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ROOT_W - 1))
                begin
                    cnt_next   = '0;
                    done_next  = 1'b1;
                    state_next = DS_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DS_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        dig_reg  <= dig_next;
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign stat.busy = (state_reg != DS_IDLE);
    assign stat.done = done_reg;
    assign root      = root_reg;

endmodule

FILE: hdl/max_distance_window_centroid_core.sv
// channel   direction  handshake              payload
// apb       in / out   psel penable pready    paddr pwdata prdata (window_len, target_x/y/z)
// point     in         in_valid / in_stall    x y z last
// result    out        out_valid / out_stall  mean_x mean_y mean_z too_few
//
// one point runs from accept to the next accept through these steps:
// digit-serial squarer, bit-serial root, then done flag, sum and compare;
// the window gather reads one history entry per cycle while the distance unit runs
// a last point of a set that filled a window then loads and runs the bit-serial divide,
// a last point of a set with too few points goes straight to the finish state
// async active-low reset clears control and loads register defaults; history needs no clear
// in_stall is high while a point is in work or its item waits for the output register;
// a finished item waits in the output register while the next point is taken

module max_distance_window_centroid_core
    import mdwc_pkg::*;
#(
    parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    localparam int PDATA_W = (COORD_WIDTH > 32) ? 64 : 32,
    localparam int PADDR_W = (COORD_WIDTH > 32) ? 5 : 4
)
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [PADDR_W-1:0]            paddr,
    input  logic [PDATA_W-1:0]            pwdata,
    output logic [PDATA_W-1:0]            prdata,
    output logic                          pready,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_WIDTH-1:0] x,
    input  logic signed [COORD_WIDTH-1:0] y,
    input  logic signed [COORD_WIDTH-1:0] z,
    input  logic                          last,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [COORD_WIDTH-1:0] mean_x,
    output logic signed [COORD_WIDTH-1:0] mean_y,
    output logic signed [COORD_WIDTH-1:0] mean_z,
    output logic                          too_few
);

    localparam int CW     = COORD_WIDTH;
    localparam int MAG_W  = CW + 1;
    localparam int ROOT_W = MAG_W;
    localparam int LEN_W  = $clog2(WINDOW_MAX + 1);
    localparam int AW     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int SUMD_W = ROOT_W + $clog2(WINDOW_MAX);
    localparam int SUMC_W = CW + $clog2(WINDOW_MAX);
    localparam int ENT_W  = LANES * CW + ROOT_W;
    localparam int DCNT_W = $clog2(SUMC_W);

    // register map, word index
    typedef enum logic [1:0] {
        REG_WINDOW_LEN = 2'd0,
        REG_TARGET_X   = 2'd1,
        REG_TARGET_Y   = 2'd2,
        REG_TARGET_Z   = 2'd3
    } cfg_reg_t;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_DIST  = 7'b0000010,
        ST_SUM   = 7'b0000100,
        ST_CMP   = 7'b0001000,
        ST_DLOAD = 7'b0010000,
        ST_DIV   = 7'b0100000,
        ST_FIN   = 7'b1000000
    } state_t;

    // ---------------------------------------------------------------- config
    logic [WINDOW_LEN_W-1:0]  window_len_reg;
    logic signed [CW-1:0]     target_reg [LANES];
    cfg_reg_t                 cfg_sel;
    logic                     cfg_wr;

    assign pready  = 1'b1;
    assign cfg_sel = cfg_reg_t'(paddr[PADDR_W-1 -: 2]);
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg <= WINDOW_LEN_RST;
            for (int l = 0; l < LANES; l++)
            begin
                target_reg[l] <= '0;
            end
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                REG_WINDOW_LEN: window_len_reg <= pwdata[WINDOW_LEN_W-1:0];
                REG_TARGET_X:   target_reg[0]  <= pwdata[CW-1:0];
                REG_TARGET_Y:   target_reg[1]  <= pwdata[CW-1:0];
                REG_TARGET_Z:   target_reg[2]  <= pwdata[CW-1:0];
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (cfg_sel)
            REG_WINDOW_LEN: prdata = PDATA_W'(window_len_reg);
            REG_TARGET_X:   prdata = PDATA_W'(target_reg[0]);
            REG_TARGET_Y:   prdata = PDATA_W'(target_reg[1]);
            REG_TARGET_Z:   prdata = PDATA_W'(target_reg[2]);
        endcase
    end

    // effective window length: zero acts as one, clipped to the history depth
    logic [LEN_W-1:0] eff_len;

    always_comb
    begin
        if (window_len_reg == '0)
            eff_len = LEN_W'(1);
        else if (32'(window_len_reg) > 32'(WINDOW_MAX))
            eff_len = LEN_W'(WINDOW_MAX);
        else
            eff_len = LEN_W'(window_len_reg);
    end

    // ---------------------------------------------------------------- state
    state_t                   state_reg, state_next;
    logic [LEN_W-1:0]         seen_reg, seen_next;
    logic [AW-1:0]            hist_ptr_reg, hist_ptr_next;
    logic                     have_best_reg, have_best_next;
    logic                     dist_ok_reg, dist_ok_next;
    logic                     rd_pend_reg;
    logic [LEN_W-1:0]         rd_j_reg, rd_j_next;
    logic [DCNT_W-1:0]        dcnt_reg, dcnt_next;
    logic                     out_valid_reg, out_valid_next;

    // payload of the item in work
    logic signed [CW-1:0]     cur_reg [LANES];
    logic signed [CW-1:0]     cur_next [LANES];
    logic                     last_reg, last_next;
    logic [LEN_W-1:0]         len_reg, len_next;

    // running window and best window
    logic [SUMD_W-1:0]        win_d_reg, win_d_next;
    logic signed [SUMC_W-1:0] win_c_reg [LANES];
    logic signed [SUMC_W-1:0] win_c_next [LANES];
    logic [SUMD_W-1:0]        best_d_reg, best_d_next;
    logic signed [SUMC_W-1:0] best_c_reg [LANES];
    logic signed [SUMC_W-1:0] best_c_next [LANES];
    logic [LEN_W-1:0]         best_len_reg, best_len_next;

    // serial divider lanes
    logic [SUMC_W-1:0]        num_reg [LANES];
    logic [SUMC_W-1:0]        num_next [LANES];
    logic [LEN_W-1:0]         drem_reg [LANES];
    logic [LEN_W-1:0]         drem_next [LANES];
    logic                     neg_reg [LANES];
    logic                     neg_next [LANES];

    // output register
    logic signed [CW-1:0]     mean_reg [LANES];
    logic signed [CW-1:0]     mean_next [LANES];
    logic                     too_few_reg, too_few_next;

    // history memory, one entry holds x, y, z and distance
    logic [ENT_W-1:0]         hist_mem [WINDOW_MAX];
    logic [ENT_W-1:0]         rd_data_reg;
    logic                     rd_en;
    logic [AW-1:0]            rd_addr;
    logic                     mem_we;
    logic [ENT_W-1:0]         wr_data;

    // distance unit
    mdwc_dist_stat_t          dist_stat;
    logic [ROOT_W-1:0]        dist_root;
    logic [LANES-1:0][MAG_W-1:0] mag;
    logic                     accept;

    // scratch
    logic signed [CW-1:0]     coord_in [LANES];
    logic signed [CW-1:0]     rd_c [LANES];
    logic [MAG_W-1:0]         diff_a [LANES];
    logic [MAG_W-1:0]         diff_b [LANES];
    logic [LEN_W:0]           addr_e;
    logic [LEN_W:0]           ptr_e;
    logic [LEN_W:0]           j_e;
    logic [LEN_W:0]           dtrial [LANES];
    logic [CW-1:0]            quot [LANES];
    logic                     win_full;
    logic                     take_best;
    logic                     can_load;

    assign coord_in[0] = x;
    assign coord_in[1] = y;
    assign coord_in[2] = z;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid & ~in_stall;
    assign can_load = ~out_valid_reg | ~out_stall;

    // exact |coord - target| per lane, both orders in parallel
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            diff_a[l] = {coord_in[l][CW-1], coord_in[l]} - {target_reg[l][CW-1], target_reg[l]};
            diff_b[l] = {target_reg[l][CW-1], target_reg[l]} - {coord_in[l][CW-1], coord_in[l]};
            mag[l]    = diff_a[l][MAG_W-1] ? diff_b[l] : diff_a[l];
        end
    end

    mdwc_dist #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dist (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .mag   (mag),
        .stat  (dist_stat),
        .root  (dist_root)
    );

    // gather address: older entry j places behind the new one, around the ring
    always_comb
    begin
        ptr_e = (LEN_W + 1)'(hist_ptr_reg);
        j_e   = (LEN_W + 1)'(rd_j_reg);
        if (ptr_e >= j_e)
            addr_e = ptr_e - j_e;
        else
            addr_e = ptr_e + (LEN_W + 1)'(WINDOW_MAX) - j_e;
        rd_addr = addr_e[AW-1:0];
    end

    assign rd_en   = (state_reg == ST_DIST) && (rd_j_reg < len_reg);
    assign mem_we  = (state_reg == ST_SUM);
    assign wr_data = {cur_reg[0], cur_reg[1], cur_reg[2], dist_root};

    always_ff @(posedge clk)
    begin
        if (mem_we)
            hist_mem[hist_ptr_reg] <= wr_data;
        if (rd_en)
            rd_data_reg <= hist_mem[rd_addr];
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            rd_c[l] = rd_data_reg[ENT_W-1-l*CW -: CW];
        end
    end

    // ---------------------------------------------------------------- control
    always_comb
    begin
        state_next     = state_reg;
        seen_next      = seen_reg;
        hist_ptr_next  = hist_ptr_reg;
        have_best_next = have_best_reg;
        dist_ok_next   = dist_ok_reg | dist_stat.done;
        rd_j_next      = rd_j_reg;
        dcnt_next      = dcnt_reg;
        out_valid_next = out_valid_reg & out_stall;
        cur_next       = cur_reg;
        last_next      = last_reg;
        len_next       = len_reg;
        win_d_next     = win_d_reg;
        win_c_next     = win_c_reg;
        best_d_next    = best_d_reg;
        best_c_next    = best_c_reg;
        best_len_next  = best_len_reg;
        num_next       = num_reg;
        drem_next      = drem_reg;
        neg_next       = neg_reg;
        mean_next      = mean_reg;
        too_few_next   = too_few_reg;

        win_full  = (seen_reg >= len_reg);
        take_best = win_full && (!have_best_reg || (win_d_reg > best_d_reg));

        for (int l = 0; l < LANES; l++)
        begin
            dtrial[l] = {drem_reg[l], num_reg[l][SUMC_W-1]};
            quot[l]   = num_reg[l][CW-1:0];
        end

        // fold in one gathered history entry
        if (rd_pend_reg)
        begin
            win_d_next = win_d_reg + SUMD_W'(rd_data_reg[ROOT_W-1:0]);
            for (int l = 0; l < LANES; l++)
            begin
                win_c_next[l] = win_c_reg[l] + SUMC_W'(rd_c[l]);
            end
        end
        if (rd_en)
            rd_j_next = rd_j_reg + 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    for (int l = 0; l < LANES; l++)
                    begin
                        cur_next[l]   = coord_in[l];
                        win_c_next[l] = SUMC_W'(coord_in[l]);
                    end
                    last_next    = last;
                    len_next     = eff_len;
                    win_d_next   = '0;
                    rd_j_next    = LEN_W'(1);
                    dist_ok_next = 1'b0;
                    state_next   = ST_DIST;
                end
            end
            ST_DIST:
            begin
                if (dist_ok_reg && !rd_en && !rd_pend_reg)
                    state_next = ST_SUM;
            end
            ST_SUM:
            begin
                win_d_next    = win_d_reg + SUMD_W'(dist_root);
                hist_ptr_next = (hist_ptr_reg == AW'(WINDOW_MAX - 1)) ? '0 : hist_ptr_reg + 1'b1;
                if (seen_reg < LEN_W'(WINDOW_MAX))
                    seen_next = seen_reg + 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                // ties keep the earlier window
                if (take_best)
                begin
                    best_d_next    = win_d_reg;
                    best_c_next    = win_c_reg;
                    best_len_next  = len_reg;
                    have_best_next = 1'b1;
                end
                if (!last_reg)
                    state_next = ST_IDLE;
                else if (have_best_reg || take_best)
                    state_next = ST_DLOAD;
                else
                    state_next = ST_FIN;
            end
            ST_DLOAD:
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    neg_next[l]  = best_c_reg[l][SUMC_W-1];
                    num_next[l]  = best_c_reg[l][SUMC_W-1] ? -best_c_reg[l] : best_c_reg[l];
                    drem_next[l] = '0;
                end
                dcnt_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                // restoring divide of the magnitudes, one quotient bit per cycle
                for (int l = 0; l < LANES; l++)
                begin
                    if (dtrial[l] >= {1'b0, best_len_reg})
                    begin
                        drem_next[l] = LEN_W'(dtrial[l] - {1'b0, best_len_reg});
                        num_next[l]  = {num_reg[l][SUMC_W-2:0], 1'b1};
                    end
                    else
                    begin
                        drem_next[l] = dtrial[l][LEN_W-1:0];
                        num_next[l]  = {num_reg[l][SUMC_W-2:0], 1'b0};
                    end
                end
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == DCNT_W'(SUMC_W - 1))
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (can_load)
                begin
                    for (int l = 0; l < LANES; l++)
                    begin
                        if (have_best_reg)
                            mean_next[l] = neg_reg[l] ? -quot[l] : quot[l];
                        else
                            mean_next[l] = '0;
                    end
                    too_few_next   = ~have_best_reg;
                    out_valid_next = 1'b1;
                    // set done, back to an empty window
                    seen_next      = '0;
                    hist_ptr_next  = '0;
                    have_best_next = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seen_reg      <= '0;
            hist_ptr_reg  <= '0;
            have_best_reg <= 1'b0;
            dist_ok_reg   <= 1'b0;
            rd_pend_reg   <= 1'b0;
            rd_j_reg      <= '0;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seen_reg      <= seen_next;
            hist_ptr_reg  <= hist_ptr_next;
            have_best_reg <= have_best_next;
            dist_ok_reg   <= dist_ok_next;
            rd_pend_reg   <= rd_en;
            rd_j_reg      <= rd_j_next;
            dcnt_reg      <= dcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        last_reg     <= last_next;
        len_reg      <= len_next;
        win_d_reg    <= win_d_next;
        win_c_reg    <= win_c_next;
        best_d_reg   <= best_d_next;
        best_c_reg   <= best_c_next;
        best_len_reg <= best_len_next;
        num_reg      <= num_next;
        drem_reg     <= drem_next;
        neg_reg      <= neg_next;
        mean_reg     <= mean_next;
        too_few_reg  <= too_few_next;
    end

    assign out_valid = out_valid_reg;
    assign mean_x    = mean_reg[0];
    assign mean_y    = mean_reg[1];
    assign mean_z    = mean_reg[2];
    assign too_few   = too_few_reg;

    // ---------------------------------------------------------------- checks
    a_too_few_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && too_few) |-> (mean_x == '0 && mean_y == '0 && mean_z == '0))
        else $error("too_few item carries nonzero means");

    a_sum_after_gather: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUM) |-> (!rd_pend_reg && rd_j_reg >= len_reg && !dist_stat.busy))
        else $error("window sum taken before gather or root finished");

    a_best_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        have_best_reg |-> (best_len_reg != '0 && best_len_reg <= LEN_W'(WINDOW_MAX)))
        else $error("best window length out of range");

    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !dist_stat.busy)
        else $error("point accepted while distance unit busy");

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import mdwc_pkg::*;

    // register indexes, byte address is four times the index
    localparam int REG_WINDOW_LEN = 0;
    localparam int REG_TARGET_X   = 1;
    localparam int REG_TARGET_Y   = 2;
    localparam int REG_TARGET_Z   = 3;

    localparam int CW = COORD_WIDTH_DEF;
    localparam int RING_DEPTH = WINDOW_MAX_DEF;

    localparam logic signed [CW-1:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [CW-1:0] COORD_MIN = 32'sh8000_0000;

    localparam int SETTLE_CYCLES = 200;
    localparam int HOLD_CYCLES   = 1000;
    localparam int PHASE_ITEMS   = 228;
    localparam int CYCLE_LIMIT   = 1_000_000;

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 last;
    } point_t;

    typedef struct {
        logic signed [CW-1:0] mean_x;
        logic signed [CW-1:0] mean_y;
        logic signed [CW-1:0] mean_z;
        logic                 too_few;
    } centroid_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic signed [CW-1:0] x = '0;
    logic signed [CW-1:0] y = '0;
    logic signed [CW-1:0] z = '0;
    logic                 last = 1'b0;

    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic signed [CW-1:0] mean_x;
    logic signed [CW-1:0] mean_y;
    logic signed [CW-1:0] mean_z;
    logic                 too_few;

    // stimulus and expectations
    point_t    pending_points[$];
    centroid_t expected_centroids[$];
    int        mismatch_count = 0;
    int        cycle_count = 0;

    // idling knobs, percent per cycle
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // long receiver hold-off, requested by the stimulus, counted by the receiver
    logic hold_request = 1'b0;
    logic hold_done = 1'b0;
    int   hold_count = 0;

    logic point_taken = 1'b0;

    // shadow of the block's registers
    logic [WINDOW_LEN_W-1:0] win_len_reg = WINDOW_LEN_RST;
    logic signed [CW-1:0]    tgt_x = '0;
    logic signed [CW-1:0]    tgt_y = '0;
    logic signed [CW-1:0]    tgt_z = '0;

    // shadow of the set in progress
    logic signed [CW-1:0] ring_x[RING_DEPTH];
    logic signed [CW-1:0] ring_y[RING_DEPTH];
    logic signed [CW-1:0] ring_z[RING_DEPTH];
    logic [CW:0]          ring_dist[RING_DEPTH];
    int     ring_wr = 0;
    int     points_seen = 0;
    logic   best_valid = 1'b0;
    longint best_len = 0;
    longint best_dsum = 0;
    longint best_sx = 0;
    longint best_sy = 0;
    longint best_sz = 0;

    max_distance_window_centroid_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .x         (x),
        .y         (y),
        .z         (z),
        .last      (last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .mean_x    (mean_x),
        .mean_y    (mean_y),
        .mean_z    (mean_z),
        .too_few   (too_few)
    );

    always #2 clk = ~clk;

    // squared difference of one coordinate, exact in 68 bits
    function automatic logic [67:0] diff_squared(logic signed [CW-1:0] a, logic signed [CW-1:0] b);
        logic signed [33:0] d;
        logic [67:0]        m;
        d = 34'(a) - 34'(b);
        if (d < 0)
            d = -d;
        m = 68'(d);
        return m * m;
    endfunction

    // integer square root rounded down, two radicand bits per step
    function automatic logic [CW:0] floor_sqrt(logic [67:0] radicand);
        logic [39:0] rem;
        logic [39:0] root;
        logic [39:0] trial;
        rem = '0;
        root = '0;
        for (int i = 33; i >= 0; i--)
        begin
            rem = {rem[37:0], radicand[2*i +: 2]};
            trial = {root[37:0], 2'b01};
            root = {root[38:0], 1'b0};
            if (rem >= trial)
            begin
                rem = rem - trial;
                root[0] = 1'b1;
            end
        end
        return root[CW:0];
    endfunction

    function automatic int effective_len();
        if (win_len_reg == 0)
            return 1;
        if (win_len_reg > RING_DEPTH)
            return RING_DEPTH;
        return int'(win_len_reg);
    endfunction

    // advance the set by one accepted point, queue the centroid on a last point
    function automatic void track_point(point_t p);
        int        len;
        int        j;
        longint    dsum;
        longint    sx;
        longint    sy;
        longint    sz;
        centroid_t c;

        ring_x[ring_wr] = p.x;
        ring_y[ring_wr] = p.y;
        ring_z[ring_wr] = p.z;
        ring_dist[ring_wr] = floor_sqrt(diff_squared(p.x, tgt_x) + diff_squared(p.y, tgt_y)
                                        + diff_squared(p.z, tgt_z));
        ring_wr = (ring_wr + 1) % RING_DEPTH;
        if (points_seen < RING_DEPTH)
            points_seen++;

        // the length in force now decides the window, the best keeps its own
        len = effective_len();
        if (points_seen >= len)
        begin
            dsum = 0;
            sx = 0;
            sy = 0;
            sz = 0;
            for (int k = 1; k <= len; k++)
            begin
                j = (ring_wr + RING_DEPTH - k) % RING_DEPTH;
                dsum += longint'(ring_dist[j]);
                sx += longint'(ring_x[j]);
                sy += longint'(ring_y[j]);
                sz += longint'(ring_z[j]);
            end
            // ties keep the earlier window
            if (!best_valid || dsum > best_dsum)
            begin
                best_valid = 1'b1;
                best_len = len;
                best_dsum = dsum;
                best_sx = sx;
                best_sy = sy;
                best_sz = sz;
            end
        end

        if (p.last)
        begin
            if (best_valid)
            begin
                // signed division truncates toward zero
                c.mean_x = CW'(best_sx / best_len);
                c.mean_y = CW'(best_sy / best_len);
                c.mean_z = CW'(best_sz / best_len);
                c.too_few = 1'b0;
            end
            else
            begin
                c.mean_x = '0;
                c.mean_y = '0;
                c.mean_z = '0;
                c.too_few = 1'b1;
            end
            expected_centroids = {expected_centroids, c};

            // a new set starts clean, registers stay
            ring_wr = 0;
            points_seen = 0;
            best_valid = 1'b0;
            best_len = 0;
            best_dsum = 0;
            best_sx = 0;
            best_sy = 0;
            best_sz = 0;
        end
    endfunction

    // accept side: check results first, then predict from the accepted point
    always @(posedge clk)
    begin : watch_ports
        centroid_t want;
        if (out_valid && !out_stall)
        begin
            if (expected_centroids.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected centroid: %0d %0d %0d too_few=%b",
                             mean_x, mean_y, mean_z, too_few);
            end
            else
            begin
                want = expected_centroids.pop_front();
                if (mean_x !== want.mean_x || mean_y !== want.mean_y
                    || mean_z !== want.mean_z || too_few !== want.too_few)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("centroid mismatch: expected %0d %0d %0d too_few=%b, got %0d %0d %0d too_few=%b",
                                 want.mean_x, want.mean_y, want.mean_z, want.too_few,
                                 mean_x, mean_y, mean_z, too_few);
                end
            end
        end

        point_taken = in_valid && !in_stall;
        if (point_taken)
            track_point('{x, y, z, last});
    end

    // point driver: a new item only once the offered one is taken or nothing is offered
    always @(negedge clk)
    begin : drive_points
        point_t nxt;
        if (!in_valid || point_taken)
        begin
            if (pending_points.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = pending_points.pop_front();
                in_valid <= 1'b1;
                x <= nxt.x;
                y <= nxt.y;
                z <= nxt.z;
                last <= nxt.last;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // result receiver: random stalls, plus one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_request && !hold_done)
        begin
            out_stall <= 1'b1;
            hold_count++;
            if (hold_count >= HOLD_CYCLES)
                hold_done = 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // setup cycle, then access cycle until pready
    task automatic set_register(int index, logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 4'(4 * index);
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (index)
            REG_WINDOW_LEN: win_len_reg = value[WINDOW_LEN_W-1:0];
            REG_TARGET_X:   tgt_x = value;
            REG_TARGET_Y:   tgt_y = value;
            REG_TARGET_Z:   tgt_z = value;
            default: ;
        endcase
    endtask

    task automatic set_target(logic [31:0] tx, logic [31:0] ty, logic [31:0] tz);
        set_register(REG_TARGET_X, tx);
        set_register(REG_TARGET_Y, ty);
        set_register(REG_TARGET_Z, tz);
    endtask

    task automatic queue_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz, logic pl);
        point_t p;
        p.x = px;
        p.y = py;
        p.z = pz;
        p.last = pl;
        pending_points = {pending_points, p};
    endtask

    // everything sent and answered, then room for a point still in work
    task automatic wait_idle();
        while (pending_points.size() != 0 || in_valid || expected_centroids.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // mix of full range, extremes, near target and near origin
    function automatic logic [31:0] pick_coord(logic [31:0] centre);
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(5))
            0: r = r[0] ? COORD_MIN : COORD_MAX;
            1: r = centre + 32'($urandom_range(1 << 18)) - 32'(1 << 17);
            2: r = {{8{r[23]}}, r[23:0]};
            default: ;
        endcase
        return r;
    endfunction

    task automatic random_phase(int ph);
        int queued;
        int set_len;
        int span;

        case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
            default: begin send_idle_pct = 29; recv_stall_pct = 29; end
        endcase

        // window length extremes first, out of range values included
        case (ph)
            0: set_register(REG_WINDOW_LEN, 16);
            1: set_register(REG_WINDOW_LEN, 1);
            2: set_register(REG_WINDOW_LEN, 0);
            3: set_register(REG_WINDOW_LEN, 31);
            default: set_register(REG_WINDOW_LEN, $urandom_range(31));
        endcase
        case (ph)
            0: set_target(0, 0, 0);
            1: set_target(COORD_MIN, COORD_MAX, COORD_MIN);
            2: set_target(COORD_MAX, COORD_MAX, COORD_MAX);
            default: set_target($urandom, {{12{1'b0}}, 20'($urandom)}, -32'($urandom_range(1 << 20)));
        endcase

        span = 2 * effective_len() + 6;
        queued = 0;
        while (queued < PHASE_ITEMS)
        begin
            // mostly full sets, some of only one to three points
            if ($urandom_range(9) == 0)
                set_len = $urandom_range(1, 3);
            else
                set_len = $urandom_range(1, span);
            for (int k = 0; k < set_len; k++)
                queue_point(pick_coord(tgt_x), pick_coord(tgt_y), pick_coord(tgt_z),
                            k == set_len - 1);
            queued += set_len;
        end

        // leave a set open so the next window length applies mid-set
        if (ph % 3 == 1)
            for (int k = 0; k < 3; k++)
                queue_point(pick_coord(tgt_x), pick_coord(tgt_y), pick_coord(tgt_z), 1'b0);

        wait_idle();
    endtask

    // run limit
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // extreme distances against an extreme target, window of two
        set_register(REG_WINDOW_LEN, 2);
        set_target(COORD_MAX, COORD_MIN, COORD_MAX);
        queue_point(COORD_MIN, COORD_MAX, COORD_MIN, 1'b0);
        queue_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
        queue_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
        // a lone point never fills the window
        queue_point(0, 0, 0, 1'b1);
        wait_idle();

        // zero length acts as one, equal distances keep the first window
        set_register(REG_WINDOW_LEN, 0);
        set_target(0, 0, 0);
        queue_point(3 << 16, 0, 0, 1'b0);
        queue_point(0, -(3 << 16), 0, 1'b0);
        queue_point(0, 0, 3 << 16, 1'b1);
        wait_idle();

        // means of negative and odd sums truncate toward zero
        set_register(REG_WINDOW_LEN, 3);
        queue_point(-1, -2, 5, 1'b0);
        queue_point(0, 0, 0, 1'b0);
        queue_point(0, 0, 0, 1'b1);
        wait_idle();

        // receiver holds off while single point sets pile up behind it
        set_register(REG_WINDOW_LEN, 1);
        hold_request = 1'b1;
        for (int k = 0; k < 24; k++)
            queue_point(pick_coord(0), pick_coord(0), pick_coord(0), 1'b1);
        wait_idle();

        for (int ph = 0; ph < 8; ph++)
            random_phase(ph);

        if (mismatch_count == 0 && expected_centroids.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
